// ===== rtl/ssu_pkg.sv =====
package ssu_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int CMD_W       = 3;
  localparam int COUNT_W     = 5;
  localparam int POS_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int LEVEL_W     = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_COUNT  = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic del;
  } cell_ctl_t;

  typedef struct packed {
    logic hit;
    logic seen;
    logic deeper;
    logic deepest;
  } cell_stat_t;

endpackage

// ===== rtl/ssu_if.sv =====
interface ssu_in_if;
  import ssu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] operand_value;

  modport source (output valid, output cmd, output operand_value, input ready);
  modport sink   (input valid, input cmd, input operand_value, output ready);
endinterface

interface ssu_out_if;
  import ssu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] popped_value;
  logic [COUNT_W-1:0]      match_count;
  logic [POS_W-1:0]        match_position;
  logic                    match_found;
  logic [STATUS_W-1:0]     status;
  logic [LEVEL_W-1:0]      fill_level;

  modport source (
    output valid, output popped_value, output match_count, output match_position,
    output match_found, output status, output fill_level, input ready
  );
  modport sink (
    input valid, input popped_value, input match_count, input match_position,
    input match_found, input status, input fill_level, output ready
  );
endinterface

// ===== rtl/ssu_cell.sv =====
module ssu_cell (
  input  logic                      clk,
  input  ssu_pkg::cell_ctl_t        ctl,
  input  logic [ssu_pkg::VAL_W-1:0] upper_val,
  input  logic [ssu_pkg::VAL_W-1:0] lower_val,
  input  logic [ssu_pkg::VAL_W-1:0] operand,
  input  logic                      occupied,
  input  logic                      seen_in,
  input  logic                      deeper_in,
  output logic [ssu_pkg::VAL_W-1:0] value,
  output ssu_pkg::cell_stat_t       stat
);
  import ssu_pkg::*;

  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] value_nxt;
  logic             hit;

  assign hit          = occupied && (value_r == operand);
  assign stat.hit     = hit;
  assign stat.seen    = seen_in | hit;
  assign stat.deeper  = deeper_in | hit;
  assign stat.deepest = hit & ~deeper_in;
  assign value        = value_r;

  always_comb begin
    priority if (ctl.push) begin
      value_nxt = upper_val;
    end else if (ctl.pop || (ctl.del && (seen_in | hit))) begin
      value_nxt = lower_val;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== rtl/searchable_stack_unit.sv =====
// Bounded LIFO stack of signed 32-bit values with count, find-deepest and
// delete-topmost commands, held in a row of cells with the top of the stack in
// the first cell; each cell compares its value with the operand and shifts up
// or down with its neighbors. A transaction captures the command in the idle
// state, then runs in the exec state, in which every cell compares and shifts
// and the result is registered; no command is taken until it ends. A new command
// is accepted while the previous result still waits on the output; execution
// stalls only while that result has not been taken. One result per command.
module searchable_stack_unit (
  input  logic        clk,
  input  logic        rst_n,
  ssu_in_if.sink      in_chan,
  ssu_out_if.source   out_chan
);
  import ssu_pkg::*;

  state_t                  state_r;
  state_t                  state_nxt;
  cmd_t                    cmd_r;
  logic [VAL_W-1:0]        operand_r;
  logic [FILL_W-1:0]       fill_r;
  logic [FILL_W-1:0]       fill_nxt;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] popped_r;
  logic [COUNT_W-1:0]      count_r;
  logic [POS_W-1:0]        pos_r;
  logic                    found_r;
  logic [STATUS_W-1:0]     status_r;
  logic [LEVEL_W-1:0]      level_r;

  logic                    in_take;
  logic                    exec_go;
  logic                    full;
  logic                    empty;
  cell_ctl_t               ctl;
  logic [VAL_W-1:0]        cell_val [STACK_DEPTH];
  cell_stat_t              cell_st  [STACK_DEPTH];
  logic [FILL_W-1:0]       hit_cnt;
  logic [IDX_W-1:0]        deep_idx;

  logic signed [VAL_W-1:0] popped_nxt;
  logic [FILL_W-1:0]       count_nxt;
  logic [FILL_W-1:0]       pos_nxt;
  logic                    found_nxt;
  status_t                 status_nxt;

  assign full  = (fill_r == FILL_W'(STACK_DEPTH));
  assign empty = (fill_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_chan.ready = 1'b0;
    exec_go       = 1'b0;
    unique case (state_r)
      ST_IDLE: in_chan.ready = 1'b1;
      ST_EXEC: exec_go = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  assign in_take = in_chan.valid && in_chan.ready;

  always_comb begin
    ctl.push = exec_go && (cmd_r == CMD_PUSH) && !full;
    ctl.pop  = exec_go && (cmd_r == CMD_POP) && !empty;
    ctl.del  = exec_go && (cmd_r == CMD_DELETE);
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] upper_val;
    logic [VAL_W-1:0] lower_val;
    logic             seen_in;
    logic             deeper_in;

    if (i == 0) begin : g_top
      assign upper_val = operand_r;
      assign seen_in   = 1'b0;
    end else begin : g_mid_up
      assign upper_val = cell_val[i-1];
      assign seen_in   = cell_st[i-1].seen;
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign lower_val = cell_val[i];
      assign deeper_in = 1'b0;
    end else begin : g_mid_dn
      assign lower_val = cell_val[i+1];
      assign deeper_in = cell_st[i+1].deeper;
    end

    ssu_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .upper_val (upper_val),
      .lower_val (lower_val),
      .operand   (operand_r),
      .occupied  (FILL_W'(i) < fill_r),
      .seen_in   (seen_in),
      .deeper_in (deeper_in),
      .value     (cell_val[i]),
      .stat      (cell_st[i])
    );
  end

  always_comb begin
    hit_cnt  = '0;
    deep_idx = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      hit_cnt = hit_cnt + FILL_W'(cell_st[i].hit);
      if (cell_st[i].deepest) deep_idx = deep_idx | IDX_W'(i);
    end
  end

  always_comb begin
    popped_nxt = '0;
    count_nxt  = '0;
    pos_nxt    = '0;
    found_nxt  = 1'b0;
    status_nxt = STS_OK;
    fill_nxt   = fill_r;
    unique case (cmd_r)
      CMD_PUSH: begin
        if (full) status_nxt = STS_OVERFLOW;
        else      fill_nxt   = fill_r + FILL_W'(1);
      end
      CMD_POP: begin
        if (empty) begin
          status_nxt = STS_UNDERFLOW;
        end else begin
          popped_nxt = cell_val[0];
          fill_nxt   = fill_r - FILL_W'(1);
        end
      end
      CMD_COUNT: count_nxt = hit_cnt;
      CMD_FIND: begin
        found_nxt = cell_st[STACK_DEPTH-1].seen;
        if (found_nxt) pos_nxt = FILL_W'(deep_idx);
      end
      CMD_DELETE: begin
        found_nxt = cell_st[STACK_DEPTH-1].seen;
        if (found_nxt) fill_nxt = fill_r - FILL_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r     <= cmd_t'(in_chan.cmd);
      operand_r <= in_chan.operand_value;
    end
    if (exec_go) begin
      popped_r <= popped_nxt;
      count_r  <= COUNT_W'(count_nxt);
      pos_r    <= POS_W'(pos_nxt);
      found_r  <= found_nxt;
      status_r <= status_nxt;
      level_r  <= LEVEL_W'(fill_nxt);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.popped_value   = popped_r;
  assign out_chan.match_count    = count_r;
  assign out_chan.match_position = pos_r;
  assign out_chan.match_found    = found_r;
  assign out_chan.status         = status_r;
  assign out_chan.fill_level     = level_r;

endmodule
